[hdl/mpbm_pkg.sv]
// Shared types, codes and default sizes of the multi-pattern byte matcher.
// Used by multi_pattern_byte_matcher and its testbench; depends on nothing.
package mpbm_pkg;

	localparam int DEF_NUM_STATES      = 256;
	localparam int DEF_MAX_PATTERNS    = 32;
	localparam int DEF_MAX_PATTERN_LEN = 32;
	localparam int DEF_POSITION_BITS   = 20;
	localparam int RESULT_CAP          = 32;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_BUILD  = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_MATCH       = 3'd0,
		STAT_BUILT       = 3'd1,
		STAT_STATES_FULL = 3'd2,
		STAT_PATS_FULL   = 3'd3,
		STAT_TOO_LONG    = 3'd4,
		STAT_EMPTY       = 3'd5,
		STAT_NOT_BUILT   = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD,
		ST_STATUS,
		ST_B_INIT,
		ST_B_RC_RD,
		ST_B_RC_CHK,
		ST_B_POP,
		ST_B_R,
		ST_B_FR,
		ST_B_U_RD,
		ST_B_U_CHK,
		ST_B_F_CHK,
		ST_B_F_NXT,
		ST_B_OWN,
		ST_S_CHK,
		ST_S_FL,
		ST_S_OWN,
		ST_S_M1,
		ST_S_M2
	} state_t;

endpackage

[hdl/multi_pattern_byte_matcher.sv]
// Top level of the multi-pattern byte matcher: sequencer, registers and tables.
// Depends on mpbm_pkg and mpbm_ram.
//
// Usage. Items enter on the item channel (command, symbol, begin_req, finish)
// under item_valid/item_ready and results leave on the result channel under
// result_valid/result_ready. An add item appends one pattern byte to the trie,
// a build item computes the fail and output links breadth-first, and a search
// item steps the automaton by one text byte and reports each pattern ending
// there, at most RESULT_CAP, that of the reached state first, then the output-link chain.
// Every result carries last, set on the final result of its item.
// Timing. One item is worked at a time; item_ready is high only while the
// sequencer is idle. The edge table has a single read port, one access per
// cycle; the work of a search grows with each fail link followed and each
// reported match, and that of a build with each edge slot scanned, each
// queued state, each edge found and each fail link followed.
// A result sits in an output register, so the next item is taken while the
// receiver stalls; only the next result waits.
// Reset. After arst_n is released a clearing pass writes every edge-table and
// own-pattern entry to zero; item_ready stays low until it ends.
module multi_pattern_byte_matcher #(
	parameter int NUM_STATES      = mpbm_pkg::DEF_NUM_STATES,
	parameter int MAX_PATTERNS    = mpbm_pkg::DEF_MAX_PATTERNS,
	parameter int MAX_PATTERN_LEN = mpbm_pkg::DEF_MAX_PATTERN_LEN,
	parameter int POSITION_BITS   = mpbm_pkg::DEF_POSITION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  symbol,
	input  logic        begin_req,
	input  logic        finish,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [4:0]  pattern_id,
	output logic [5:0]  pattern_length,
	output logic [19:0] first_pos,
	output logic [19:0] end_pos,
	output logic [7:0]  end_state,
	output logic        last
);
	import mpbm_pkg::*;

	localparam int SB  = $clog2(NUM_STATES);
	localparam int EAW = SB + 8;
	localparam int USB = $clog2(NUM_STATES + 1);
	localparam int IB  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int PCB = $clog2(MAX_PATTERNS + 1);
	localparam int LB  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PB  = POSITION_BITS;

	state_t state_q, state_d;

	logic [EAW-1:0] clr_q;
	logic [USB-1:0] used_q, head_q, tail_q;
	logic [PCB-1:0] pc_q;
	logic [SB-1:0]  ins_q, cur_q, s_q, u_q, f_q, v_q, r_q, fr_q, m_q;
	logic [LB-1:0]  len_q;
	logic [PB-1:0]  pos_q, mpos_q;
	logic           built_q, fin_q;
	logic [7:0]     sym_q;
	status_t        stat_q;
	logic [IB-1:0]  id_q;
	logic [4:0]     n_q;

	// Table ports.
	logic           e_we;
	logic [EAW-1:0] e_wa, e_ra;
	logic [SB-1:0]  e_wd, e_rd;
	logic           o_we;
	logic [SB-1:0]  o_wa, o_ra;
	logic [PCB-1:0] o_wd, o_rd;
	logic           f_we;
	logic [SB-1:0]  f_wa, f_ra, f_wd, f_rd;
	logic           l_we;
	logic [SB-1:0]  l_wa, l_ra, l_wd, l_rd;
	logic           q_we;
	logic [SB-1:0]  q_wa, q_ra, q_wd, q_rd;
	logic           p_we;
	logic [IB-1:0]  p_wa, p_ra;
	logic [LB-1:0]  p_wd, p_rd;

	mpbm_ram #(.AW(EAW), .WIDTH(SB)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
	);
	mpbm_ram #(.AW(SB), .WIDTH(PCB)) u_own (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
	);
	mpbm_ram #(.AW(SB), .WIDTH(SB)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
	);
	mpbm_ram #(.AW(SB), .WIDTH(SB)) u_outl (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	mpbm_ram #(.AW(SB), .WIDTH(SB)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);
	mpbm_ram #(.AW(IB), .WIDTH(LB)) u_plen (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);

	// Decisions shared by the next-state, table and register logic.
	logic           accept;
	logic [SB-1:0]  ins_e, srch_e;
	logic [LB-1:0]  len_e;
	logic           a_new, a_full, a_room;
	logic [SB-1:0]  a_nxt;
	logic [LB-1:0]  a_len1;
	logic           tail_room, sym_end;
	logic           walk;
	logic [SB-1:0]  m_d;
	logic [PCB-1:0] id_full;
	logic           out_free, push, push_last;
	logic [LB-1:0]  lm1;
	logic [PB-1:0]  lm1x, start_d;
	logic           res_last;

	assign accept    = item_valid && item_ready;
	assign ins_e     = begin_req ? '0 : ins_q;
	assign len_e     = begin_req ? '0 : len_q;
	assign srch_e    = begin_req ? '0 : cur_q;
	assign a_new     = (e_rd == '0);
	assign a_full    = a_new && (used_q >= USB'(NUM_STATES));
	assign a_room    = (pc_q < PCB'(MAX_PATTERNS));
	assign a_nxt     = a_new ? used_q[SB-1:0] : e_rd;
	assign a_len1    = len_q + LB'(1);
	assign tail_room = (tail_q < USB'(NUM_STATES));
	assign sym_end   = (sym_q == 8'hFF);
	assign walk      = (s_q != '0) && (e_rd == '0);
	assign m_d       = (o_rd != '0) ? s_q : l_rd;
	assign id_full   = o_rd - PCB'(1);
	assign out_free  = !result_valid || result_ready;
	assign res_last  = (l_rd == '0) || (n_q == 5'(RESULT_CAP - 1));

	// A pattern longer than the bytes seen so far starts at position zero.
	assign lm1     = p_rd - LB'(1);
	assign lm1x    = {{(PB-LB){1'b0}}, lm1};
	assign start_d = ((p_rd == '0) || (lm1x > mpos_q)) ? '0 : (mpos_q - lm1x);

	assign item_ready = (state_q == ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_ADD: begin
							state_d = (len_e >= LB'(MAX_PATTERN_LEN)) ? ST_STATUS : ST_ADD;
						end
						CMD_BUILD: begin
							state_d = (pc_q == '0) ? ST_STATUS : ST_B_INIT;
						end
						CMD_SEARCH: begin
							state_d = built_q ? ST_S_CHK : ST_STATUS;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (a_full || (fin_q && !a_room)) state_d = ST_STATUS;
				else state_d = ST_IDLE;
			end
			ST_STATUS: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_B_INIT:   state_d = ST_B_RC_RD;
			ST_B_RC_RD:  state_d = ST_B_RC_CHK;
			ST_B_RC_CHK: state_d = sym_end ? ST_B_POP : ST_B_RC_RD;
			ST_B_POP:    state_d = (head_q == tail_q) ? ST_STATUS : ST_B_R;
			ST_B_R:      state_d = ST_B_FR;
			ST_B_FR:     state_d = ST_B_U_CHK;
			ST_B_U_RD:   state_d = ST_B_U_CHK;
			ST_B_U_CHK: begin
				if (e_rd != '0) state_d = ST_B_F_CHK;
				else state_d = sym_end ? ST_B_POP : ST_B_U_RD;
			end
			ST_B_F_CHK: begin
				state_d = ((f_q != '0) && (e_rd == '0)) ? ST_B_F_NXT : ST_B_OWN;
			end
			ST_B_F_NXT:  state_d = ST_B_F_CHK;
			ST_B_OWN:    state_d = sym_end ? ST_B_POP : ST_B_U_RD;
			ST_S_CHK:    state_d = walk ? ST_S_FL : ST_S_OWN;
			ST_S_FL:     state_d = ST_S_CHK;
			ST_S_OWN:    state_d = (m_d == '0) ? ST_IDLE : ST_S_M1;
			ST_S_M1:     state_d = ST_S_M2;
			ST_S_M2: begin
				if (out_free) state_d = res_last ? ST_IDLE : ST_S_M1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table controls and result pushes.
	always_comb begin
		e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
		o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
		f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
		q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
		p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
		push = 1'b0;
		push_last = 1'b1;
		unique case (state_q)
			ST_CLR: begin
				e_we = 1'b1; e_wa = clr_q;
				o_we = 1'b1; o_wa = clr_q[SB-1:0];
			end
			ST_IDLE: begin
				e_ra = (command == CMD_SEARCH) ? {srch_e, symbol} : {ins_e, symbol};
			end
			ST_ADD: begin
				if (!a_full) begin
					if (a_new) begin
						e_we = 1'b1; e_wa = {ins_q, sym_q}; e_wd = a_nxt;
						o_we = 1'b1; o_wa = a_nxt; o_wd = '0;
					end
					if (fin_q && a_room) begin
						o_we = 1'b1; o_wa = a_nxt; o_wd = pc_q + PCB'(1);
						p_we = 1'b1; p_wa = pc_q[IB-1:0]; p_wd = a_len1;
					end
				end
			end
			ST_STATUS: begin
				push = out_free;
			end
			ST_B_INIT: begin
				f_we = 1'b1;
				l_we = 1'b1;
			end
			ST_B_RC_RD: begin
				e_ra = {{SB{1'b0}}, sym_q};
			end
			ST_B_RC_CHK: begin
				if ((e_rd != '0) && tail_room) begin
					f_we = 1'b1; f_wa = e_rd;
					l_we = 1'b1; l_wa = e_rd;
					q_we = 1'b1; q_wa = tail_q[SB-1:0]; q_wd = e_rd;
				end
			end
			ST_B_POP: begin
				q_ra = head_q[SB-1:0];
			end
			ST_B_R: begin
				f_ra = q_rd;
			end
			ST_B_FR: begin
				e_ra = {r_q, sym_q};
			end
			ST_B_U_RD: begin
				e_ra = {r_q, sym_q};
			end
			ST_B_U_CHK: begin
				e_ra = {fr_q, sym_q};
			end
			ST_B_F_CHK: begin
				if ((f_q != '0) && (e_rd == '0)) begin
					f_ra = f_q;
				end else begin
					f_we = 1'b1; f_wa = u_q; f_wd = e_rd;
					o_ra = e_rd;
					l_ra = e_rd;
				end
			end
			ST_B_F_NXT: begin
				e_ra = {f_rd, sym_q};
			end
			ST_B_OWN: begin
				l_we = 1'b1; l_wa = u_q; l_wd = (o_rd != '0) ? v_q : l_rd;
				if (tail_room) begin
					q_we = 1'b1; q_wa = tail_q[SB-1:0]; q_wd = u_q;
				end
			end
			ST_S_CHK: begin
				if (walk) begin
					f_ra = s_q;
				end else begin
					o_ra = e_rd;
					l_ra = e_rd;
				end
			end
			ST_S_FL: begin
				e_ra = {f_rd, sym_q};
			end
			ST_S_OWN: begin
				o_ra = m_d;
			end
			ST_S_M1: begin
				p_ra = id_full[IB-1:0];
				l_ra = m_q;
			end
			ST_S_M2: begin
				// The read addresses are held so the data stays put during a stall.
				p_ra = id_q;
				l_ra = m_q;
				push = out_free;
				push_last = res_last;
				if (out_free && !res_last) o_ra = l_rd;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			used_q  <= USB'(1);
			pc_q    <= '0;
			ins_q   <= '0;
			len_q   <= '0;
			cur_q   <= '0;
			pos_q   <= '0;
			built_q <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + EAW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						sym_q <= symbol;
						fin_q <= finish;
						unique case (command)
							CMD_ADD: begin
								built_q <= 1'b0;
								if (len_e >= LB'(MAX_PATTERN_LEN)) begin
									ins_q  <= '0;
									len_q  <= '0;
									stat_q <= STAT_TOO_LONG;
								end else begin
									ins_q <= ins_e;
									len_q <= len_e;
								end
							end
							CMD_BUILD: begin
								ins_q <= '0;
								len_q <= '0;
								cur_q <= '0;
								pos_q <= '0;
								if (pc_q == '0) begin
									built_q <= 1'b0;
									stat_q  <= STAT_EMPTY;
								end
							end
							CMD_SEARCH: begin
								if (!built_q) begin
									stat_q <= STAT_NOT_BUILT;
								end else begin
									s_q <= srch_e;
									if (begin_req) pos_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: begin
					if (a_full) begin
						ins_q  <= '0;
						len_q  <= '0;
						stat_q <= STAT_STATES_FULL;
					end else begin
						if (a_new) used_q <= used_q + USB'(1);
						if (fin_q) begin
							ins_q <= '0;
							len_q <= '0;
							if (a_room) pc_q <= pc_q + PCB'(1);
							else stat_q <= STAT_PATS_FULL;
						end else begin
							ins_q <= a_nxt;
							len_q <= a_len1;
						end
					end
				end
				ST_B_INIT: begin
					sym_q  <= '0;
					head_q <= '0;
					tail_q <= '0;
				end
				ST_B_RC_CHK: begin
					if ((e_rd != '0) && tail_room) tail_q <= tail_q + USB'(1);
					sym_q <= sym_q + 8'd1;
				end
				ST_B_POP: begin
					if (head_q == tail_q) begin
						built_q <= 1'b1;
						stat_q  <= STAT_BUILT;
					end else begin
						head_q <= head_q + USB'(1);
					end
				end
				ST_B_R: begin
					r_q   <= q_rd;
					sym_q <= '0;
				end
				ST_B_FR: begin
					fr_q <= f_rd;
				end
				ST_B_U_CHK: begin
					if (e_rd != '0) begin
						u_q <= e_rd;
						f_q <= fr_q;
					end else begin
						sym_q <= sym_q + 8'd1;
					end
				end
				ST_B_F_CHK: begin
					v_q <= e_rd;
				end
				ST_B_F_NXT: begin
					f_q <= f_rd;
				end
				ST_B_OWN: begin
					if (tail_room) tail_q <= tail_q + USB'(1);
					sym_q <= sym_q + 8'd1;
				end
				ST_S_CHK: begin
					if (!walk) begin
						s_q    <= e_rd;
						cur_q  <= e_rd;
						mpos_q <= pos_q;
						if (pos_q != '1) pos_q <= pos_q + PB'(1);
					end
				end
				ST_S_FL: begin
					s_q <= f_rd;
				end
				ST_S_OWN: begin
					m_q <= m_d;
					n_q <= '0;
				end
				ST_S_M1: begin
					id_q <= id_full[IB-1:0];
				end
				ST_S_M2: begin
					if (out_free && !res_last) begin
						m_q <= l_rd;
						n_q <= n_q + 5'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: a held result does not stop the next item from entering.
	logic [2:0]     status_q;
	logic [4:0]     pattern_id_q;
	logic [5:0]     pattern_length_q;
	logic [19:0]    first_pos_q, end_pos_q;
	logic [7:0]     end_state_q;
	logic           last_q, result_valid_q;
	logic [IB+4:0]  id_pad;
	logic [LB+5:0]  len_pad;
	logic [PB+19:0] start_pad, end_pad;
	logic [SB+7:0]  state_pad;

	assign id_pad    = {5'b0, id_q};
	assign len_pad   = {6'b0, p_rd};
	assign start_pad = {20'b0, start_d};
	assign end_pad   = {20'b0, mpos_q};
	assign state_pad = {8'b0, s_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			last_q <= push_last;
			if (state_q == ST_STATUS) begin
				status_q         <= stat_q;
				pattern_id_q     <= '0;
				pattern_length_q <= '0;
				first_pos_q      <= '0;
				end_pos_q        <= '0;
				end_state_q      <= '0;
			end else begin
				status_q         <= STAT_MATCH;
				pattern_id_q     <= id_pad[4:0];
				pattern_length_q <= len_pad[5:0];
				first_pos_q      <= start_pad[19:0];
				end_pos_q        <= end_pad[19:0];
				end_state_q      <= state_pad[7:0];
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign pattern_id     = pattern_id_q;
	assign pattern_length = pattern_length_q;
	assign first_pos      = first_pos_q;
	assign end_pos        = end_pos_q;
	assign end_state      = end_state_q;
	assign last           = last_q;

`ifndef NO_ASSERTIONS
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) && (used_q <= USB'(NUM_STATES)))
		else $error("state count out of range");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PCB'(MAX_PATTERNS))
		else $error("pattern count out of range");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LB'(MAX_PATTERN_LEN))
		else $error("insert length out of range");
	a_not_built: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_SEARCH) && !built_q) |=> (state_q == ST_STATUS))
		else $error("search before build did not answer a status");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("breadth-first queue head passed its tail");
`endif

endmodule

[hdl/mpbm_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; instantiated for each table of the matcher.
module mpbm_ram #(
	parameter int AW    = 8,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [(1<<AW)];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[verif/multi_pattern_byte_matcher_test.sv]
// Self-checking testbench for the multi-pattern byte matcher.
// Depends on mpbm_pkg and the multi_pattern_byte_matcher RTL, which uses mpbm_ram.
module multi_pattern_byte_matcher_test;
	import mpbm_pkg::*;

	localparam int STATES   = DEF_NUM_STATES;
	localparam int PATS     = DEF_MAX_PATTERNS;
	localparam int PAT_LEN  = DEF_MAX_PATTERN_LEN;
	localparam int POS_MAX  = (1 << DEF_POSITION_BITS) - 1;
	// A build over a full trie scans every edge slot of each state, and the clearing
	// pass writes every edge-table entry; neither channel moves during either.
	localparam int WATCHDOG = 600000;
	localparam int NO_TYPED = -1;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] sym;
		logic       beg;
		logic       fin;
		int         typed;  // hand-written expected status, or NO_TYPED
		bit         calm;   // no idling on either side while this item is sent
		bit         drain;  // hold off until every expected result has come
	} stim_t;

	typedef struct {
		logic [2:0]  status;
		logic [4:0]  id;
		logic [5:0]  len;
		logic [19:0] spos;
		logic [19:0] epos;
		logic [7:0]  st;
		logic        last;
	} match_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  command = CMD_ADD;
	logic [7:0]  symbol = 8'd0;
	logic        begin_req = 1'b0;
	logic        finish = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  status;
	logic [4:0]  pattern_id;
	logic [5:0]  pattern_length;
	logic [19:0] first_pos;
	logic [19:0] end_pos;
	logic [7:0]  end_state;
	logic        last;

	// Side information that travels with the item being offered.
	int          cur_typed = NO_TYPED;
	bit          calm = 1'b0;

	stim_t       stim_q[$];
	match_t      match_q[$];
	int          errors = 0;
	int          quiet = 0;

	// Shadow copy of the automaton.
	logic [7:0]  trie [0:STATES*256-1];
	logic [7:0]  fail_of [0:STATES-1];
	logic [7:0]  outl_of [0:STATES-1];
	logic [5:0]  owner [0:STATES-1];
	logic [5:0]  plen [0:PATS-1];
	logic [7:0]  bfsq [0:STATES-1];
	int          n_states, n_pats, ins_st, ins_len, cur_st, tpos;
	bit          built;

	multi_pattern_byte_matcher u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.command(command), .symbol(symbol), .begin_req(begin_req), .finish(finish),
		.result_valid(result_valid), .result_ready(result_ready),
		.status(status), .pattern_id(pattern_id), .pattern_length(pattern_length),
		.first_pos(first_pos), .end_pos(end_pos), .end_state(end_state), .last(last)
	);

	always #1 clk = ~clk;

	function automatic match_t status_only(logic [2:0] s);
		match_t r;
		r = '{s, 5'd0, 6'd0, 20'd0, 20'd0, 8'd0, 1'b1};
		return r;
	endfunction

	// Adds one pattern byte to the shadow trie; returns a status or NO_TYPED.
	function automatic int trie_add(logic [7:0] sym, logic beg, logic fin);
		int nxt;
		built = 1'b0;
		if (beg) begin
			ins_st = 0;
			ins_len = 0;
		end
		if (ins_len >= PAT_LEN) begin
			ins_st = 0;
			ins_len = 0;
			return STAT_TOO_LONG;
		end
		nxt = int'(trie[{ins_st[7:0], sym}]);
		if (nxt == 0) begin
			if (n_states >= STATES) begin
				ins_st = 0;
				ins_len = 0;
				return STAT_STATES_FULL;
			end
			nxt = n_states++;
			owner[nxt] = 6'd0;
			trie[{ins_st[7:0], sym}] = nxt[7:0];
		end
		ins_st = nxt;
		ins_len++;
		if (fin) begin
			nxt = ins_st;
			ins_st = 0;
			if (n_pats >= PATS) begin
				ins_len = 0;
				return STAT_PATS_FULL;
			end
			owner[nxt] = 6'(n_pats + 1);
			plen[n_pats] = 6'(ins_len);
			n_pats++;
			ins_len = 0;
		end
		return NO_TYPED;
	endfunction

	// Breadth-first pass that fills the fail and output links.
	function automatic logic [2:0] link_trie();
		int head, tail, r, u, f, v;
		ins_st = 0;
		ins_len = 0;
		cur_st = 0;
		tpos = 0;
		if (n_pats == 0) begin
			built = 1'b0;
			return STAT_EMPTY;
		end
		head = 0;
		tail = 0;
		fail_of[0] = 8'd0;
		outl_of[0] = 8'd0;
		for (int c = 0; c < 256; c++) begin
			u = int'(trie[{8'd0, c[7:0]}]);
			if (u != 0 && tail < STATES) begin
				fail_of[u] = 8'd0;
				outl_of[u] = 8'd0;
				bfsq[tail++] = u[7:0];
			end
		end
		while (head < tail) begin
			r = int'(bfsq[head++]);
			for (int c = 0; c < 256; c++) begin
				u = int'(trie[{r[7:0], c[7:0]}]);
				if (u != 0) begin
					f = int'(fail_of[r]);
					while (f != 0 && trie[{f[7:0], c[7:0]}] == 0)
						f = int'(fail_of[f]);
					v = int'(trie[{f[7:0], c[7:0]}]);
					fail_of[u] = v[7:0];
					outl_of[u] = (owner[v] != 0) ? v[7:0] : outl_of[v];
					if (tail < STATES)
						bfsq[tail++] = u[7:0];
				end
			end
		end
		built = 1'b1;
		return STAT_BUILT;
	endfunction

	// Works out every result one accepted item causes and queues it.
	task automatic predict_matches(logic [1:0] cmd, logic [7:0] sym, logic beg,
			logic fin, int typed);
		match_t got[$];
		match_t r;
		int s, m, pos, id, ln, n;
		if (cmd == CMD_ADD) begin
			s = trie_add(sym, beg, fin);
			if (s != NO_TYPED)
				got.push_back(status_only(3'(s)));
		end else if (cmd == CMD_BUILD) begin
			got.push_back(status_only(link_trie()));
		end else if (!built) begin
			got.push_back(status_only(STAT_NOT_BUILT));
		end else begin
			if (beg) begin
				cur_st = 0;
				tpos = 0;
			end
			s = cur_st;
			while (s != 0 && trie[{s[7:0], sym}] == 0)
				s = int'(fail_of[s]);
			s = int'(trie[{s[7:0], sym}]);
			cur_st = s;
			pos = tpos;
			tpos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
			m = (owner[s] != 0) ? s : int'(outl_of[s]);
			n = 0;
			while (m != 0 && n < RESULT_CAP) begin
				id = int'(owner[m]) - 1;
				ln = (id < PATS) ? int'(plen[id]) : 0;
				r.status = STAT_MATCH;
				r.id = 5'(id);
				r.len = 6'(ln);
				r.spos = 20'((ln == 0 || ln - 1 > pos) ? 0 : pos - (ln - 1));
				r.epos = 20'(pos);
				r.st = 8'(s);
				r.last = 1'b0;
				got.push_back(r);
				n++;
				m = int'(outl_of[m]);
			end
			if (n > 0)
				got[n-1].last = 1'b1;
		end
		// Rows with a hand-written status stand in for the predictor's answer.
		if (typed != NO_TYPED)
			match_q.push_back(status_only(3'(typed)));
		else
			foreach (got[i])
				match_q.push_back(got[i]);
	endtask

	// Input side is recorded and the result side is compared at the same edge,
	// using the values that held just before it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				predict_matches(command, symbol, begin_req, finish, cur_typed);
			if (result_valid && result_ready) begin
				if (match_q.size() == 0) begin
					$error("unexpected result: status %0d", status);
					errors++;
				end else begin
					match_t e;
					e = match_q.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						errors++;
					end
					if (pattern_id !== e.id) begin
						$error("pattern_id: expected %0d, got %0d", e.id, pattern_id);
						errors++;
					end
					if (pattern_length !== e.len) begin
						$error("pattern_length: expected %0d, got %0d", e.len,
							pattern_length);
						errors++;
					end
					if (first_pos !== e.spos) begin
						$error("first_pos: expected %0d, got %0d", e.spos, first_pos);
						errors++;
					end
					if (end_pos !== e.epos) begin
						$error("end_pos: expected %0d, got %0d", e.epos, end_pos);
						errors++;
					end
					if (end_state !== e.st) begin
						$error("end_state: expected %0d, got %0d", e.st, end_state);
						errors++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						errors++;
					end
				end
			end
		end
	end

	// The receiver stalls at random except in the calm stretch.
	always @(posedge clk)
		result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);

	// The watchdog counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("multi_pattern_byte_matcher test failed");
			$finish;
		end
	end

	task automatic push_item(cmd_t c, logic [7:0] s, logic b, logic f, bit cl = 0,
			bit dr = 0, int typed = NO_TYPED);
		stim_q.push_back('{c, s, b, f, typed, cl, dr});
	endtask

	// One pattern of n bytes, from a small alphabet so patterns overlap, or from any byte when alpha is 0.
	task automatic push_pattern(int n, int alpha, bit cl);
		for (int i = 0; i < n; i++)
			push_item(CMD_ADD, (alpha > 0) ? 8'(8'h61 + $urandom_range(alpha - 1))
				: 8'($urandom_range(255)), i == 0, i == n - 1, cl);
	endtask

	task automatic build_stimulus();
		bit cl;
		// Directed rows: empty build, search before build, overlapping patterns,
		// a duplicate pattern, a pattern without a begin flag, the byte extremes,
		// a search that loses its begin, and an add that clears the built mark.
		push_item(CMD_BUILD, 8'h00, 0, 0, 0, 0, STAT_EMPTY);
		push_item(CMD_SEARCH, 8'h61, 1, 0, 0, 0, STAT_NOT_BUILT);
		push_item(CMD_ADD, 8'h61, 1, 0);
		push_item(CMD_ADD, 8'h62, 0, 1);
		push_item(CMD_ADD, 8'h62, 1, 1);
		push_item(CMD_ADD, 8'h62, 1, 0);
		push_item(CMD_ADD, 8'h61, 0, 0);
		push_item(CMD_ADD, 8'h62, 0, 1);
		push_item(CMD_ADD, 8'h61, 1, 0);
		push_item(CMD_ADD, 8'h62, 0, 1);
		push_item(CMD_ADD, 8'h00, 0, 0);
		push_item(CMD_ADD, 8'hFF, 0, 1);
		push_item(CMD_BUILD, 8'hFF, 1, 1, 0, 1, STAT_BUILT);
		push_item(CMD_SEARCH, 8'h62, 1, 0);
		push_item(CMD_SEARCH, 8'h61, 0, 0);
		push_item(CMD_SEARCH, 8'h62, 0, 1);
		push_item(CMD_SEARCH, 8'h00, 0, 0);
		push_item(CMD_SEARCH, 8'hFF, 0, 0);
		push_item(CMD_SEARCH, 8'h61, 1, 0);
		push_item(CMD_SEARCH, 8'h62, 0, 0);
		push_item(CMD_ADD, 8'h63, 1, 1);
		push_item(CMD_SEARCH, 8'h63, 1, 0, 0, 0, STAT_NOT_BUILT);
		push_item(CMD_BUILD, 8'h00, 0, 0, 0, 1, STAT_BUILT);
		push_item(CMD_SEARCH, 8'h63, 0, 0);

		// Random phases: a few overlapping patterns, at times an early search, a build,
		// then a text with the odd restart and the odd stray byte. Phase three runs without idling.
		for (int p = 0; p < 6; p++) begin
			cl = (p == 3);
			for (int k = $urandom_range(5, 3); k > 0; k--)
				push_pattern($urandom_range(4, 1), 4, cl);
			if ($urandom_range(1))
				push_item(CMD_SEARCH, 8'($urandom_range(255)), 1, 0, cl);
			push_item(CMD_BUILD, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)), cl, 1);
			for (int t = 0; t < 20; t++)
				push_item(CMD_SEARCH, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
					: 8'(8'h61 + $urandom_range(3)), t == 0 || $urandom_range(19) == 0,
					1'($urandom_range(1)), cl);
		end

		// One overlong pattern, then long random patterns that fill the state table.
		push_pattern(PAT_LEN + 1, 0, 0);
		for (int k = 0; k < 7; k++)
			push_pattern(PAT_LEN, 0, 0);
		push_item(CMD_BUILD, 8'h00, 0, 0, 0, 1);
		for (int t = 0; t < 20; t++)
			push_item(CMD_SEARCH, ($urandom_range(1)) ? 8'($urandom_range(255))
				: 8'(8'h61 + $urandom_range(3)), t == 0, 0);
	endtask

	task automatic send_item(stim_t it);
		int gap;
		gap = 0;
		if (!it.calm)
			while ($urandom_range(99) < 34)
				gap++;
		if (it.drain || gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// The queue is looked at mid-cycle, after the last accepted item has
			// been predicted.
			if (it.drain) begin
				@(negedge clk);
				while (match_q.size() != 0)
					@(negedge clk);
				@(posedge clk);
			end
		end
		calm <= it.calm;
		command <= it.cmd;
		symbol <= it.sym;
		begin_req <= it.beg;
		finish <= it.fin;
		cur_typed <= it.typed;
		item_valid <= 1'b1;
		// item_ready only moves at a rising edge, so its mid-cycle value tells
		// whether the coming edge takes the item.
		do
			@(negedge clk);
		while (!item_ready);
		@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < STATES * 256; i++)
			trie[i] = 8'd0;
		for (int i = 0; i < STATES; i++) begin
			owner[i] = 6'd0;
			fail_of[i] = 8'd0;
			outl_of[i] = 8'd0;
		end
		n_states = 1;
		n_pats = 0;
		ins_st = 0;
		ins_len = 0;
		cur_st = 0;
		tpos = 0;
		built = 1'b0;
		build_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_q.size() != 0)
			send_item(stim_q.pop_front());
		item_valid <= 1'b0;
		calm <= 1'b0;
		@(negedge clk);
		while (match_q.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && match_q.size() == 0)
			$display("multi_pattern_byte_matcher test passed");
		else
			$display("multi_pattern_byte_matcher test failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/mpbm_pkg.sv
hdl/mpbm_ram.sv
hdl/multi_pattern_byte_matcher.sv
verif/multi_pattern_byte_matcher_test.sv
